[rtl/stt_pkg.sv]
// stt_pkg: shared types, codes and character tables for the source text tokenizer.
// No dependencies. Used by stt_scan, stt_emit and source_text_tokenizer.
`default_nettype none

package stt_pkg;

  localparam int CNT_W = 24;
  localparam logic [CNT_W-1:0] CNT_MAX = 24'hFFFFFF;

  localparam int CLS_W = 3;
  localparam logic [CLS_W-1:0] CLS_OP      = 3'd0;
  localparam logic [CLS_W-1:0] CLS_SPECIAL = 3'd1;
  localparam logic [CLS_W-1:0] CLS_DIGIT   = 3'd2;
  localparam logic [CLS_W-1:0] CLS_KEYWORD = 3'd3;
  localparam logic [CLS_W-1:0] CLS_IDENT   = 3'd4;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_US    = 8'h5F;

  localparam int IN_W  = 8;
  localparam int OUT_W = 64;

  typedef enum logic [2:0] {
    SCAN_NORMAL,
    SCAN_WORD,
    SCAN_SLASH,
    SCAN_LINE,
    SCAN_BLOCK,
    SCAN_BLOCK_STAR
  } scan_mode_t;

  typedef enum logic [1:0] {
    EMIT_IDLE,
    EMIT_WORD,
    EMIT_SLASH,
    EMIT_SINGLE
  } emit_state_t;

  // Work handed from the scanner to the emitter for one accepted transaction.
  typedef struct packed {
    logic             word;         // flush the stored word first
    logic             kw;           // stored word is a keyword
    logic             slash;        // emit a pending '/' operator first
    logic             single;       // then one single-character token
    logic [CLS_W-1:0] single_cls;
    logic [7:0]       single_char;
    logic [CNT_W-1:0] line;         // line all tokens of this transaction report
  } stt_act_t;

  // Keywords, first character in byte 0.
  localparam int NUM_KW = 6;
  localparam int KW_MAXLEN = 5;
  localparam logic [KW_MAXLEN-1:0][7:0] KW_TEXT [NUM_KW] = '{
    {8'h00, 8'h00, "t", "n", "i"},
    {8'h00, "n", "i", "a", "m"},
    {8'h00, 8'h00, 8'h00, "f", "i"},
    {8'h00, "e", "s", "l", "e"},
    {8'h00, 8'h00, 8'h00, "o", "d"},
    {"e", "l", "i", "h", "w"}
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd3, 3'd4, 3'd2, 3'd4, 3'd2, 3'd5};

  function automatic logic [7:0] kw_char(input int k, input logic [5:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    if (pos < 6'(KW_MAXLEN)) ch = KW_TEXT[k][pos[2:0]];
    return ch;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return c == "+" || c == "-" || c == CH_STAR;
  endfunction

  function automatic logic is_special(input logic [7:0] c);
    return c == ";" || c == "{" || c == "}" || c == "(" || c == ")" ||
           c == "?" || c == "@" || c == "!" || c == "%";
  endfunction

endpackage

`default_nettype wire

[rtl/stt_lex_mem.sv]
// stt_lex_mem: lexeme character store, one write and one registered read port.
// No dependencies. Read-first: a read and write of one entry in a cycle returns old data.
`default_nettype none

module stt_lex_mem #(
  parameter int DEPTH = 19,
  parameter int AW    = 5
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/stt_scan.sv]
// stt_scan: scan-mode machine, word length and keyword tracking, line counter.
// Depends on stt_pkg. Writes word characters into stt_lex_mem.
`default_nettype none

module stt_scan #(
  parameter int MAX_LEXEME = 19,
  parameter int LENW       = 5,
  parameter int AW         = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [7:0]        text_char,
  input  wire logic              end_of_text,
  output stt_pkg::stt_act_t      act,
  output logic      [LENW-1:0]   word_len,
  output logic                   we,
  output logic      [AW-1:0]     waddr,
  output logic      [7:0]        wdata
);

  stt_pkg::scan_mode_t           mode, mode_next;
  logic [LENW-1:0]               len, len_next;
  logic [stt_pkg::NUM_KW-1:0]    hit, hit_next;
  logic [stt_pkg::CNT_W-1:0]     line_count;
  logic                          line_bump;
  logic                          kw_hit;

  stt_pkg::scan_mode_t           nb_mode;
  logic                          nb_single;
  logic [stt_pkg::CLS_W-1:0]     nb_cls;
  logic                          nb_word;
  logic                          nb_nl;
  logic                          apply_nb;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= stt_pkg::SCAN_NORMAL;
      len        <= '0;
      hit        <= '0;
      line_count <= stt_pkg::CNT_W'(1);
    end else begin
      mode <= mode_next;
      len  <= len_next;
      hit  <= hit_next;
      if (line_bump && line_count != stt_pkg::CNT_MAX) line_count <= line_count + 1'b1;
    end
  end

  always_comb begin
    kw_hit = 1'b0;
    for (int k = 0; k < stt_pkg::NUM_KW; k++)
      if (hit[k] && 6'(len) == 6'(stt_pkg::KW_LEN[k])) kw_hit = 1'b1;
  end

  // What a byte does in normal scanning.
  always_comb begin
    nb_mode   = stt_pkg::SCAN_NORMAL;
    nb_single = 1'b0;
    nb_cls    = stt_pkg::CLS_OP;
    nb_word   = 1'b0;
    nb_nl     = 1'b0;
    if (text_char == stt_pkg::CH_HASH) begin
      nb_mode = stt_pkg::SCAN_LINE;
    end else if (stt_pkg::is_space(text_char)) begin
      nb_nl = (text_char == stt_pkg::CH_NL);
    end else if (text_char == stt_pkg::CH_SLASH) begin
      nb_mode = stt_pkg::SCAN_SLASH;
    end else if (stt_pkg::is_op(text_char)) begin
      nb_single = 1'b1;
    end else if (stt_pkg::is_special(text_char)) begin
      nb_single = 1'b1;
      nb_cls    = stt_pkg::CLS_SPECIAL;
    end else if (stt_pkg::is_digit(text_char)) begin
      nb_single = 1'b1;
      nb_cls    = stt_pkg::CLS_DIGIT;
    end else if (stt_pkg::is_alpha(text_char)) begin
      nb_word = 1'b1;
      nb_mode = stt_pkg::SCAN_WORD;
    end
  end

  always_comb begin
    mode_next       = mode;
    len_next        = len;
    hit_next        = hit;
    line_bump       = 1'b0;
    apply_nb        = 1'b0;
    act             = '0;
    act.line        = line_count;
    act.single_char = text_char;
    word_len        = len;
    we              = 1'b0;
    waddr           = AW'(len);
    wdata           = text_char;

    if (accept) begin
      if (end_of_text) begin
        unique case (mode)
          stt_pkg::SCAN_WORD: begin
            act.word = 1'b1;
            act.kw   = kw_hit;
          end
          stt_pkg::SCAN_SLASH: act.slash = 1'b1;
          stt_pkg::SCAN_LINE:  line_bump = 1'b1;
          default: ;
        endcase
        mode_next = stt_pkg::SCAN_NORMAL;
        len_next  = '0;
      end else begin
        unique case (mode)
          stt_pkg::SCAN_NORMAL: apply_nb = 1'b1;
          stt_pkg::SCAN_WORD: begin
            if (stt_pkg::is_alpha(text_char) || stt_pkg::is_digit(text_char) ||
                text_char == stt_pkg::CH_US) begin
              // characters past the limit still continue the word
              if (len < LENW'(MAX_LEXEME)) begin
                we       = 1'b1;
                len_next = len + 1'b1;
                for (int k = 0; k < stt_pkg::NUM_KW; k++)
                  hit_next[k] = hit[k] && (6'(len) < 6'(stt_pkg::KW_LEN[k])) &&
                                (text_char == stt_pkg::kw_char(k, 6'(len)));
              end
            end else begin
              act.word = 1'b1;
              act.kw   = kw_hit;
              len_next = '0;
              apply_nb = 1'b1;
            end
          end
          stt_pkg::SCAN_SLASH: begin
            if (text_char == stt_pkg::CH_SLASH) begin
              mode_next = stt_pkg::SCAN_LINE;
            end else if (text_char == stt_pkg::CH_STAR) begin
              mode_next = stt_pkg::SCAN_BLOCK;
            end else begin
              act.slash = 1'b1;
              apply_nb  = 1'b1;
            end
          end
          stt_pkg::SCAN_LINE: begin
            if (text_char == stt_pkg::CH_NL) begin
              line_bump = 1'b1;
              mode_next = stt_pkg::SCAN_NORMAL;
            end
          end
          stt_pkg::SCAN_BLOCK: begin
            if (text_char == stt_pkg::CH_NL) line_bump = 1'b1;
            else if (text_char == stt_pkg::CH_STAR) mode_next = stt_pkg::SCAN_BLOCK_STAR;
          end
          stt_pkg::SCAN_BLOCK_STAR: begin
            if (text_char == stt_pkg::CH_SLASH) begin
              mode_next = stt_pkg::SCAN_NORMAL;
            end else if (text_char != stt_pkg::CH_STAR) begin
              line_bump = (text_char == stt_pkg::CH_NL);
              mode_next = stt_pkg::SCAN_BLOCK;
            end
          end
          default: begin
            mode_next = stt_pkg::SCAN_NORMAL;
            len_next  = '0;
          end
        endcase

        if (apply_nb) begin
          mode_next      = nb_mode;
          act.single     = nb_single;
          act.single_cls = nb_cls;
          line_bump      = nb_nl;
          if (nb_word) begin
            // a new word starts at entry 0; the memory is read-first
            we       = 1'b1;
            waddr    = '0;
            len_next = LENW'(1);
            for (int k = 0; k < stt_pkg::NUM_KW; k++)
              hit_next[k] = (text_char == stt_pkg::kw_char(k, 6'd0));
          end
        end
      end
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LENW'(MAX_LEXEME))
    else $error("word length beyond limit");

  a_word_nonempty: assert property (@(posedge clk) disable iff (rst)
    mode == stt_pkg::SCAN_WORD |-> len != '0)
    else $error("word mode with empty word");

endmodule

`default_nettype wire

[rtl/stt_emit.sv]
// stt_emit: token sequencer, token counter and output register.
// Depends on stt_pkg. Reads word characters from stt_lex_mem.
`default_nettype none

module stt_emit #(
  parameter int LENW = 5,
  parameter int AW   = 5
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   accept,
  input  wire stt_pkg::stt_act_t      act,
  input  wire logic [LENW-1:0]        word_len_in,
  output logic                        idle,
  output logic                        re,
  output logic      [AW-1:0]          raddr,
  input  wire logic [7:0]             rdata,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic      [stt_pkg::OUT_W-1:0] m_tdata,
  output logic                        m_tlast
);

  stt_pkg::emit_state_t         state, state_next;
  logic [AW-1:0]                idx;
  logic [LENW-1:0]              word_len;
  logic [stt_pkg::CLS_W-1:0]    word_cls;
  logic                         has_single;
  logic [stt_pkg::CLS_W-1:0]    single_cls;
  logic [7:0]                   single_char;
  logic [stt_pkg::CNT_W-1:0]    tok_line;
  logic [stt_pkg::CNT_W-1:0]    token_count;

  logic [stt_pkg::CNT_W-1:0]    out_line;
  logic [stt_pkg::CNT_W-1:0]    out_tok;
  logic [stt_pkg::CLS_W-1:0]    out_cls;
  logic [7:0]                   out_char;

  logic                         load;
  logic                         emit;
  logic                         emit_last;
  logic [stt_pkg::CLS_W-1:0]    emit_cls;
  logic [7:0]                   emit_char;
  logic                         word_end;

  assign load     = !m_tvalid || m_tready;
  assign idle     = (state == stt_pkg::EMIT_IDLE);
  assign word_end = (LENW'(idx) + LENW'(1)) == word_len;

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_last  = 1'b1;
    emit_cls   = single_cls;
    emit_char  = single_char;
    re         = 1'b0;
    raddr      = idx + 1'b1;
    unique case (state)
      stt_pkg::EMIT_IDLE: begin
        if (accept) begin
          re    = act.word;
          raddr = '0;
          if (act.word) state_next = stt_pkg::EMIT_WORD;
          else if (act.slash) state_next = stt_pkg::EMIT_SLASH;
          else if (act.single) state_next = stt_pkg::EMIT_SINGLE;
        end
      end
      stt_pkg::EMIT_WORD: begin
        emit_cls  = word_cls;
        emit_char = rdata;
        emit_last = word_end;
        if (load) begin
          emit = 1'b1;
          if (word_end) state_next = has_single ? stt_pkg::EMIT_SINGLE : stt_pkg::EMIT_IDLE;
          else re = 1'b1;
        end
      end
      stt_pkg::EMIT_SLASH: begin
        emit_cls  = stt_pkg::CLS_OP;
        emit_char = stt_pkg::CH_SLASH;
        if (load) begin
          emit       = 1'b1;
          state_next = has_single ? stt_pkg::EMIT_SINGLE : stt_pkg::EMIT_IDLE;
        end
      end
      stt_pkg::EMIT_SINGLE: begin
        if (load) begin
          emit       = 1'b1;
          state_next = stt_pkg::EMIT_IDLE;
        end
      end
      default: state_next = stt_pkg::EMIT_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= stt_pkg::EMIT_IDLE;
      token_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (emit && emit_last && token_count != stt_pkg::CNT_MAX)
        token_count <= token_count + 1'b1;
      if (emit) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (idle && accept) begin
      idx         <= '0;
      word_len    <= word_len_in;
      word_cls    <= act.kw ? stt_pkg::CLS_KEYWORD : stt_pkg::CLS_IDENT;
      has_single  <= act.single;
      single_cls  <= act.single_cls;
      single_char <= act.single_char;
      tok_line    <= act.line;
    end else if (state == stt_pkg::EMIT_WORD && load && !word_end) begin
      idx <= idx + 1'b1;
    end
    if (emit) begin
      out_line <= tok_line;
      out_tok  <= token_count;
      out_cls  <= emit_cls;
      out_char <= emit_char;
      m_tlast  <= emit_last;
    end
  end

  assign m_tdata = {5'b0, out_char, out_cls, out_tok, out_line};

  a_idx_in_word: assert property (@(posedge clk) disable iff (rst)
    state == stt_pkg::EMIT_WORD |-> LENW'(idx) < word_len)
    else $error("word index past stored length");

  a_word_continues: assert property (@(posedge clk) disable iff (rst)
    emit && state == stt_pkg::EMIT_WORD && !emit_last |=> state == stt_pkg::EMIT_WORD)
    else $error("word emission stopped early");

  a_tok_bump: assert property (@(posedge clk) disable iff (rst)
    emit && emit_last && token_count != stt_pkg::CNT_MAX |=>
      token_count == $past(token_count) + 1'b1)
    else $error("token counter missed a token");

  a_flush_starts: assert property (@(posedge clk) disable iff (rst)
    idle && accept && act.word |=> state == stt_pkg::EMIT_WORD)
    else $error("word flush not started");

endmodule

`default_nettype wire

[rtl/source_text_tokenizer.sv]
// source_text_tokenizer: top level of the streaming lexical analyzer.
// Depends on stt_pkg, stt_lex_mem, stt_scan and stt_emit.
//
//  channel  dir  tdata                         tlast         tuser
//  s_*      in   [7:0] text_char               end_of_text   -
//  m_*      out  line, token, class, char      lexeme_last   -
//
// A transaction without tokens leaves the sequencer idle; one with
// tokens holds s_tready low until its last character is loaded, the
// word characters coming from the lexeme memory at one read a cycle
// unless m_tready stalls them. rst is synchronous and clears the scan
// mode, counters and sequencer; the lexeme memory is not cleared.
`default_nettype none

module source_text_tokenizer #(
  parameter int MAX_LEXEME = 19
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [stt_pkg::IN_W-1:0]   s_tdata,   // [7:0] text_char
  input  wire logic                       s_tlast,   // end_of_text
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // [23:0] line_number, [47:24] token_number, [50:48] token_class,
  // [58:51] lexeme_char, [63:59] zero
  output logic      [stt_pkg::OUT_W-1:0]  m_tdata,
  output logic                            m_tlast    // lexeme_last
);

  localparam int LENW = $clog2(MAX_LEXEME + 1);
  localparam int AW   = (MAX_LEXEME > 1) ? $clog2(MAX_LEXEME) : 1;

  logic              accept;
  stt_pkg::stt_act_t act;
  logic [LENW-1:0]   word_len;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [7:0]        wdata;
  logic              re;
  logic [AW-1:0]     raddr;
  logic [7:0]        rdata;
  logic              idle;

  assign s_tready = idle;
  assign accept   = s_tvalid && s_tready;

  stt_scan #(
    .MAX_LEXEME (MAX_LEXEME),
    .LENW       (LENW),
    .AW         (AW)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .text_char   (s_tdata[7:0]),
    .end_of_text (s_tlast),
    .act         (act),
    .word_len    (word_len),
    .we          (we),
    .waddr       (waddr),
    .wdata       (wdata)
  );

  stt_lex_mem #(
    .DEPTH (MAX_LEXEME),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  stt_emit #(
    .LENW (LENW),
    .AW   (AW)
  ) u_emit (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .act         (act),
    .word_len_in (word_len),
    .idle        (idle),
    .re          (re),
    .raddr       (raddr),
    .rdata       (rdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

endmodule

`default_nettype wire

[tb/token_stream_checker.sv]
// token_stream_checker: watches both stream channels of source_text_tokenizer, predicts
// every token character from the accepted input bytes and compares field by field.
// Depends on stt_pkg for the scan modes, token classes and character codes.

module token_stream_checker #(
  parameter int MAX_WORD = 19
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [stt_pkg::IN_W-1:0]    s_tdata,
  input  logic                        s_tlast,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [stt_pkg::OUT_W-1:0]   m_tdata,
  input  logic                        m_tlast,
  output int                          fail_count,
  output int                          pending
);
  import stt_pkg::*;

  typedef struct packed {
    logic [CNT_W-1:0] line;
    logic [CNT_W-1:0] tok;
    logic [CLS_W-1:0] cls;
    logic [7:0]       ch;
    logic             last;
  } token_char_t;

  scan_mode_t       mode;
  logic [7:0]       word_buf [MAX_WORD];
  int               word_len;
  logic [CNT_W-1:0] line_cnt;
  logic [CNT_W-1:0] tok_cnt;
  token_char_t      due_q [$];
  int               errs;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic bit blank_char(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit letter_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit digit_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void add_char(input logic [CLS_W-1:0] cls, input logic [7:0] ch,
                                   input logic last);
    token_char_t t;
    t.line = line_cnt;
    t.tok  = tok_cnt;
    t.cls  = cls;
    t.ch   = ch;
    t.last = last;
    due_q.push_back(t);
  endfunction

  function automatic void add_single(input logic [CLS_W-1:0] cls, input logic [7:0] ch);
    add_char(cls, ch, 1'b1);
    tok_cnt = sat_inc(tok_cnt);
  endfunction

  function automatic bit word_is_keyword();
    string kw;
    bit    hit;
    hit = 1'b0;
    for (int k = 0; k < 6; k++) begin
      case (k)
        0: kw = "int";
        1: kw = "main";
        2: kw = "if";
        3: kw = "else";
        4: kw = "do";
        default: kw = "while";
      endcase
      if (kw.len() == word_len) begin
        bit same;
        same = 1'b1;
        for (int i = 0; i < word_len; i++)
          if (word_buf[i] != kw[i]) same = 1'b0;
        if (same) hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic void flush_word();
    logic [CLS_W-1:0] cls;
    cls = word_is_keyword() ? CLS_KEYWORD : CLS_IDENT;
    for (int i = 0; i < word_len; i++)
      add_char(cls, word_buf[i], i == word_len - 1);
    tok_cnt = sat_inc(tok_cnt);
    word_len = 0;
  endfunction

  // Byte seen in plain scanning, also the byte that ends a word or a lone slash.
  function automatic void take_plain(input logic [7:0] c);
    if (c == CH_HASH) begin
      mode = SCAN_LINE;
    end else if (blank_char(c)) begin
      if (c == CH_NL) line_cnt = sat_inc(line_cnt);
    end else if (c == CH_SLASH) begin
      mode = SCAN_SLASH;
    end else if (c == "+" || c == "-" || c == CH_STAR) begin
      add_single(CLS_OP, c);
    end else if (c == ";" || c == "{" || c == "}" || c == "(" || c == ")" ||
                 c == "?" || c == "@" || c == "!" || c == "%") begin
      add_single(CLS_SPECIAL, c);
    end else if (digit_char(c)) begin
      add_single(CLS_DIGIT, c);
    end else if (letter_char(c)) begin
      word_buf[0] = c;
      word_len = 1;
      mode = SCAN_WORD;
    end
  endfunction

  function automatic void advance(input logic [7:0] c, input logic eot);
    if (eot) begin
      case (mode)
        SCAN_WORD:  flush_word();
        SCAN_SLASH: add_single(CLS_OP, CH_SLASH);
        SCAN_LINE:  line_cnt = sat_inc(line_cnt);
        default: ;
      endcase
      mode = SCAN_NORMAL;
      word_len = 0;
    end else begin
      case (mode)
        SCAN_NORMAL: take_plain(c);
        SCAN_WORD: begin
          if (letter_char(c) || digit_char(c) || c == CH_US) begin
            // characters past the limit still extend the word
            if (word_len < MAX_WORD) begin
              word_buf[word_len] = c;
              word_len++;
            end
          end else begin
            flush_word();
            mode = SCAN_NORMAL;
            take_plain(c);
          end
        end
        SCAN_SLASH: begin
          if (c == CH_SLASH) begin
            mode = SCAN_LINE;
          end else if (c == CH_STAR) begin
            mode = SCAN_BLOCK;
          end else begin
            add_single(CLS_OP, CH_SLASH);
            mode = SCAN_NORMAL;
            take_plain(c);
          end
        end
        SCAN_LINE: begin
          if (c == CH_NL) begin
            line_cnt = sat_inc(line_cnt);
            mode = SCAN_NORMAL;
          end
        end
        SCAN_BLOCK: begin
          if (c == CH_NL) line_cnt = sat_inc(line_cnt);
          else if (c == CH_STAR) mode = SCAN_BLOCK_STAR;
        end
        SCAN_BLOCK_STAR: begin
          if (c == CH_SLASH) begin
            mode = SCAN_NORMAL;
          end else if (c != CH_STAR) begin
            if (c == CH_NL) line_cnt = sat_inc(line_cnt);
            mode = SCAN_BLOCK;
          end
        end
        default: begin
          mode = SCAN_NORMAL;
          word_len = 0;
        end
      endcase
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    token_char_t want;
    if (rst) begin
      mode = SCAN_NORMAL;
      word_len = 0;
      line_cnt = CNT_W'(1);
      tok_cnt = '0;
      due_q.delete();
    end else begin
      // input first: the prediction is queued before the output is compared
      if (s_tvalid && s_tready) advance(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (due_q.size() == 0) begin
          $error("token character with none pending: tdata %h last %b", m_tdata, m_tlast);
          errs++;
        end else begin
          want = due_q.pop_front();
          check_field("line_number", 32'(want.line), 32'(m_tdata[23:0]));
          check_field("token_number", 32'(want.tok), 32'(m_tdata[47:24]));
          check_field("token_class", 32'(want.cls), 32'(m_tdata[50:48]));
          check_field("lexeme_char", 32'(want.ch), 32'(m_tdata[58:51]));
          check_field("lexeme_last", 32'(want.last), 32'(m_tlast));
        end
      end
    end
    pending    <= due_q.size();
    fail_count <= errs;
  end

endmodule

[tb/source_text_tokenizer_tb.sv]
// source_text_tokenizer_tb: drives source bytes and end markers into the tokenizer with
// random gaps and output stalls; token_stream_checker predicts and compares the tokens.
// Depends on stt_pkg, source_text_tokenizer and token_stream_checker.

module source_text_tokenizer_tb;
  import stt_pkg::*;

  localparam int MAX_WORD     = 19;
  localparam int RANDOM_ITEMS = 430;
  localparam int STALL_LIMIT  = 3000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 40;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata = '0;
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic                 m_tlast;
  int                   fail_count;
  int                   pending;
  int                   quiet_cycles;
  int                   item_idx;
  int                   useful_items;

  source_text_tokenizer #(.MAX_LEXEME(MAX_WORD)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  token_stream_checker #(.MAX_WORD(MAX_WORD)) token_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Counts cycles in which neither channel completes a transaction.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic eot, input bit counted);
    int gap;
    // every fourth stretch of 20 bytes goes back to back
    gap = ((item_idx % 80) >= 60) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= eot;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    item_idx++;
    if (counted) useful_items++;
  endtask

  task automatic send_text(input string t);
    for (int i = 0; i < t.len(); i++) send_char(t[i], 1'b0, 1'b1);
  endtask

  function automatic logic [7:0] word_char(input bit first);
    int r;
    r = first ? $urandom_range(0, 51) : $urandom_range(0, 62);
    if (r < 26) return 8'h61 + 8'(r);
    if (r < 52) return 8'h41 + 8'(r - 26);
    if (r < 62) return 8'h30 + 8'(r - 52);
    return CH_US;
  endfunction

  task automatic send_word();
    int len;
    case ($urandom_range(0, 9))
      0: send_text("int");
      1: send_text("main");
      2: send_text("if");
      3: send_text("else");
      4: send_text("do");
      5: send_text("while");
      default: begin
        // now and then a word near or past the stored length
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 26) : $urandom_range(1, 6);
        send_char(word_char(1'b1), 1'b0, 1'b1);
        for (int i = 1; i < len; i++) send_char(word_char(1'b0), 1'b0, 1'b1);
      end
    endcase
  endtask

  // Output side: random stall per token character, one long hold to back up the input.
  initial begin
    int hold;
    int taken;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      hold = ((taken / 40) % 4 == 3) ? 0 : $urandom_range(0, 16);
      if (taken == 150) hold = LONG_HOLD;
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      taken++;
    end
  end

  initial begin
    string singles;
    string body;
    int    pick;
    int    r;
    singles = "+-*;{}()?@!%0123456789";
    body    = "*\n/ab x";
    item_idx = 0;
    useful_items = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: byte extremes, a keyword run on by a digit into an identifier, lone slash
    // and open line comment closed by the end marker, block comment closed by a star run
    send_char(8'h00, 1'b0, 1'b1);
    send_char(8'hFF, 1'b0, 1'b1);
    send_text("while1");
    send_char(CH_SLASH, 1'b0, 1'b1);
    send_char(8'hFF, 1'b1, 1'b1);
    send_char(CH_HASH, 1'b0, 1'b1);
    send_char(8'h00, 1'b1, 1'b1);
    send_text("/*\n**/?");
    send_char("a", 1'b0, 1'b1);
    send_char(8'hFF, 1'b1, 1'b1);

    while (useful_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        send_word();
      end else if (pick < 48) begin
        send_char(singles[$urandom_range(0, singles.len() - 1)], 1'b0, 1'b1);
      end else if (pick < 64) begin
        r = $urandom_range(0, 6);
        send_char((r >= 5) ? ((r == 5) ? 8'h20 : CH_NL) : 8'h09 + 8'(r), 1'b0, 1'b1);
      end else if (pick < 71) begin
        if ($urandom_range(0, 1)) send_char(CH_HASH, 1'b0, 1'b1);
        else send_text("//");
        repeat ($urandom_range(0, 6)) send_char(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        if ($urandom_range(0, 4) == 0) send_char(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        else send_char(CH_NL, 1'b0, 1'b1);
      end else if (pick < 78) begin
        send_text("/*");
        repeat ($urandom_range(0, 8)) begin
          if ($urandom_range(0, 3) == 0) send_char(8'($urandom_range(0, 255)), 1'b0, 1'b1);
          else send_char(body[$urandom_range(0, body.len() - 1)], 1'b0, 1'b1);
        end
        case ($urandom_range(0, 5))
          0: send_char(8'($urandom_range(0, 255)), 1'b1, 1'b1);
          1: send_text("**/");
          default: send_text("*/");
        endcase
      end else if (pick < 85) begin
        send_char(CH_SLASH, 1'b0, 1'b1);
      end else if (pick < 93) begin
        send_char(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end else begin
        send_char(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      end
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
